[hw/rtl/size_class_pool_allocator_unit_defines.svh]
// assertion macros for the size class pool allocator
`ifndef SIZE_CLASS_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SCPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/scpa_pkg.sv]
`default_nettype none

package scpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int USED_W     = 20;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	// default reset bases step by 256 KiB per pool
	localparam int POOL_STRIDE_LOG = 18;

	localparam int CLASS_COUNT_DEF      = 8;
	localparam int ENTRIES_PER_POOL_DEF = 256;
	localparam int MIN_CLASS_BYTES_DEF  = 8;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_EXHAUSTED,
		ST_TOO_LARGE,
		ST_FOREIGN,
		ST_STACK_FULL
	} status_t;

	typedef struct packed {
		logic              pop;
		status_t           status;
		logic [ADDR_W-1:0] addr;
		logic [USED_W-1:0] used;
	} scpa_res_t;

	function automatic logic [ADDR_W-1:0] base_reset(int unsigned idx);
		return ADDR_W'(idx) << POOL_STRIDE_LOG;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/scpa_ram.sv]
`default_nettype none

module scpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/scpa_cfg.sv]
`default_nettype none

module scpa_cfg #(
	parameter int CLASS_COUNT      = scpa_pkg::CLASS_COUNT_DEF,
	parameter int ENTRIES_PER_POOL = scpa_pkg::ENTRIES_PER_POOL_DEF,
	parameter int MIN_CLASS_BYTES  = scpa_pkg::MIN_CLASS_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [scpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic      [scpa_pkg::ADDR_W-1:0]     base [CLASS_COUNT],
	output logic      [scpa_pkg::ADDR_W:0]       limit [CLASS_COUNT]
);

	import scpa_pkg::*;

	localparam int LIM_W = ADDR_W + 1;

	logic [ADDR_W-1:0] base_q  [CLASS_COUNT];
	logic [LIM_W-1:0]  limit_q [CLASS_COUNT];

	// region span of pool i, entries times class bytes
	function automatic logic [LIM_W-1:0] span(int unsigned idx);
		return (LIM_W'(ENTRIES_PER_POOL) * LIM_W'(MIN_CLASS_BYTES)) << idx;
	endfunction

	// the region end is kept beside the base so a free only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				base_q[i]  <= base_reset(i);
				limit_q[i] <= {1'b0, base_reset(i)} + span(i);
			end
		end else begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
					base_q[i]  <= ADDR_W'(cfg_data);
					limit_q[i] <= {1'b0, ADDR_W'(cfg_data)} + span(i);
				end
			end
		end
	end

	assign base  = base_q;
	assign limit = limit_q;

endmodule

`default_nettype wire

[hw/rtl/scpa_core.sv]
`default_nettype none

module scpa_core #(
	parameter int CLASS_COUNT      = scpa_pkg::CLASS_COUNT_DEF,
	parameter int ENTRIES_PER_POOL = scpa_pkg::ENTRIES_PER_POOL_DEF,
	parameter int MIN_CLASS_BYTES  = scpa_pkg::MIN_CLASS_BYTES_DEF,
	localparam int RAM_AW = $clog2(CLASS_COUNT) + $clog2(ENTRIES_PER_POOL)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fire,
	input  wire logic                        command,
	input  wire logic [scpa_pkg::SIZE_W-1:0] request_size,
	input  wire logic [scpa_pkg::ADDR_W-1:0] free_address,
	input  wire logic [scpa_pkg::ADDR_W-1:0] base [CLASS_COUNT],
	input  wire logic [scpa_pkg::ADDR_W:0]   limit [CLASS_COUNT],
	output scpa_pkg::scpa_res_t              res,
	output logic                             ram_we,
	output logic                             ram_re,
	output logic      [RAM_AW-1:0]           ram_addr,
	output logic      [scpa_pkg::ADDR_W-1:0] ram_wdata
);

	import scpa_pkg::*;

	localparam int CLS_W = $clog2(CLASS_COUNT);
	localparam int EW    = $clog2(ENTRIES_PER_POOL);
	localparam int CW    = $clog2(ENTRIES_PER_POOL + 1);
	localparam int RW    = SIZE_W + 1;
	localparam int SH_W  = $clog2(SIZE_W + 1);

	logic [CW-1:0]     fill_q  [CLASS_COUNT];
	logic [CW-1:0]     depth_q [CLASS_COUNT];
	logic [USED_W-1:0] used_q;

	logic [SIZE_W-1:0] size_eff;
	logic [SIZE_W-1:0] size_m1;
	logic [SH_W-1:0]   shamt;
	logic [RW-1:0]     rounded;
	logic [CLS_W-1:0]  a_idx;
	logic              a_ok;
	logic [CLS_W-1:0]  f_idx;
	logic              f_ok;
	logic [CLS_W-1:0]  sel;
	logic [CW-1:0]     fill_sel;
	logic [CW-1:0]     depth_sel;
	logic [CW-1:0]     depth_m1;
	logic [USED_W-1:0] cls_used;
	logic [USED_W:0]   used_sum;
	logic [USED_W-1:0] used_add;
	logic [USED_W-1:0] used_sub;
	logic              fill_inc;
	logic              depth_inc;
	logic              depth_dec;

	function automatic logic [RW-1:0] cls_bytes(int unsigned idx);
		return RW'(MIN_CLASS_BYTES) << idx;
	endfunction

	// round the raised size up to a power of two
	always_comb begin
		size_eff = (request_size < SIZE_W'(MIN_CLASS_BYTES)) ?
			SIZE_W'(MIN_CLASS_BYTES) : request_size;
		size_m1  = size_eff - SIZE_W'(1);
		shamt    = '0;
		for (int b = 0; b < SIZE_W; b++) begin
			if (size_m1[b]) begin
				shamt = SH_W'(b + 1);
			end
		end
		rounded = RW'(1) << shamt;
	end

	// smallest fitting class, first region that holds the address
	always_comb begin
		a_idx = '0;
		a_ok  = 1'b0;
		f_idx = '0;
		f_ok  = 1'b0;
		for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
			if (cls_bytes(i) >= rounded) begin
				a_idx = CLS_W'(i);
				a_ok  = 1'b1;
			end
			if (free_address >= base[i] && {1'b0, free_address} < limit[i]) begin
				f_idx = CLS_W'(i);
				f_ok  = 1'b1;
			end
		end
	end

	always_comb begin
		sel       = (command == CMD_FREE) ? f_idx : a_idx;
		fill_sel  = fill_q[sel];
		depth_sel = depth_q[sel];
		depth_m1  = depth_sel - CW'(1);
		cls_used  = USED_W'(MIN_CLASS_BYTES) << sel;
		used_sum  = {1'b0, used_q} + {1'b0, cls_used};
		used_add  = used_sum[USED_W] ? {USED_W{1'b1}} : used_sum[USED_W-1:0];
		used_sub  = (used_q > cls_used) ? used_q - cls_used : '0;
	end

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		res.used   = used_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = {sel, depth_sel[EW-1:0]};
		ram_wdata  = free_address;
		fill_inc   = 1'b0;
		depth_inc  = 1'b0;
		depth_dec  = 1'b0;
		if (command == CMD_ALLOC) begin
			priority if (!a_ok) begin
				res.status = ST_TOO_LARGE;
			end else if (depth_sel != '0) begin
				res.pop   = 1'b1;
				res.used  = used_add;
				ram_re    = fire;
				ram_addr  = {sel, depth_m1[EW-1:0]};
				depth_dec = 1'b1;
			end else if (fill_sel >= CW'(ENTRIES_PER_POOL)) begin
				res.status = ST_EXHAUSTED;
			end else begin
				res.addr = base[sel] +
					((ADDR_W'(fill_sel) * ADDR_W'(MIN_CLASS_BYTES)) << sel);
				res.used = used_add;
				fill_inc = 1'b1;
			end
		end else begin
			priority if (!f_ok) begin
				res.status = ST_FOREIGN;
			end else if (depth_sel >= CW'(ENTRIES_PER_POOL)) begin
				res.status = ST_STACK_FULL;
			end else begin
				res.used  = used_sub;
				ram_we    = fire;
				depth_inc = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				fill_q[i]  <= '0;
				depth_q[i] <= '0;
			end
			used_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				if (sel == CLS_W'(i)) begin
					if (fill_inc) begin
						fill_q[i] <= fill_sel + CW'(1);
					end
					if (depth_inc) begin
						depth_q[i] <= depth_sel + CW'(1);
					end else if (depth_dec) begin
						depth_q[i] <= depth_m1;
					end
				end
			end
			used_q <= res.used;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/size_class_pool_allocator_unit.sv]
`default_nettype none

// Segregated size-class pool allocator. Each request transaction (tuser 0 allocate,
// 1 free) gives exactly one result transaction. A request is registered, decided in one
// pass against the per-pool fill and stack counters, and the result is registered
// together with the read of the shared free-stack memory. A new request can be taken
// every cycle while the result register is empty or being drained. The free-stack
// memory is not cleared after reset; only entries below a pool's stack depth are ever
// read. The user must write pool bases on the cfg port only while no request is in
// flight; the block itself does not enforce it.

`include "size_class_pool_allocator_unit_defines.svh"

module size_class_pool_allocator_unit #(
	parameter int CLASS_COUNT      = scpa_pkg::CLASS_COUNT_DEF,
	parameter int ENTRIES_PER_POOL = scpa_pkg::ENTRIES_PER_POOL_DEF,
	parameter int MIN_CLASS_BYTES  = scpa_pkg::MIN_CLASS_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [scpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// request_size, free_address
	input  wire logic [scpa_pkg::IN_DATA_W-1:0]  s_tdata,
	// command
	input  wire logic [0:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// block_address, status, bytes_in_use, zero pad
	output logic      [scpa_pkg::OUT_DATA_W-1:0] m_tdata
);

	import scpa_pkg::*;

	localparam int RAM_AW    = $clog2(CLASS_COUNT) + $clog2(ENTRIES_PER_POOL);
	localparam int RAM_DEPTH = CLASS_COUNT << $clog2(ENTRIES_PER_POOL);

	logic [ADDR_W-1:0] base  [CLASS_COUNT];
	logic [ADDR_W:0]   limit [CLASS_COUNT];

	logic              valid_s1;
	logic              cmd_s1;
	logic [SIZE_W-1:0] size_s1;
	logic [ADDR_W-1:0] faddr_s1;
	logic              valid_s2;
	scpa_res_t         res_s2;

	scpa_res_t         res;
	logic              adv;
	logic              ram_we;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_addr;
	logic [ADDR_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_rdata;
	logic [ADDR_W-1:0] out_addr;

	scpa_cfg #(
		.CLASS_COUNT      (CLASS_COUNT),
		.ENTRIES_PER_POOL (ENTRIES_PER_POOL),
		.MIN_CLASS_BYTES  (MIN_CLASS_BYTES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.base      (base),
		.limit     (limit)
	);

	scpa_core #(
		.CLASS_COUNT      (CLASS_COUNT),
		.ENTRIES_PER_POOL (ENTRIES_PER_POOL),
		.MIN_CLASS_BYTES  (MIN_CLASS_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (adv),
		.command      (cmd_s1),
		.request_size (size_s1),
		.free_address (faddr_s1),
		.base         (base),
		.limit        (limit),
		.res          (res),
		.ram_we       (ram_we),
		.ram_re       (ram_re),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata)
	);

	scpa_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (RAM_DEPTH)
	) u_free_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// the request moves on when the result register is empty or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				res_s2   <= res;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser[0];
			size_s1  <= s_tdata[SIZE_W-1:0];
			faddr_s1 <= s_tdata[SIZE_W +: ADDR_W];
		end
	end

	// a popped block comes straight from the memory read register
	assign out_addr = res_s2.pop ? ram_rdata : res_s2.addr;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.used, res_s2.status, out_addr};

	`SCPA_ASSERT_IMPLY(a_fail_no_addr, clk, arst_n,
		valid_s2 && res_s2.status != ST_OK, m_tdata[ADDR_W-1:0] == '0)
	`SCPA_ASSERT_IMPLY(a_pop_is_ok, clk, arst_n,
		valid_s2 && res_s2.pop, res_s2.status == ST_OK)
	`SCPA_ASSERT_NEXT(a_pop_reaches_out, clk, arst_n,
		adv && res.pop, valid_s2 && res_s2.pop)
	`SCPA_ASSERT_IMPLY(a_fail_keeps_used, clk, arst_n,
		adv && res.status != ST_OK, res.used == res_s2.used)

endmodule

`default_nettype wire
